// File: rtl/distinct_id_counter_defines.svh
// assertion macros for the distinct id counter checker
`ifndef DISTINCT_ID_COUNTER_DEFINES_SVH
`define DISTINCT_ID_COUNTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DIC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("distinct id counter check failed");

// next-cycle implication, disabled in reset
`define DIC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("distinct id counter check failed");

`endif

// File: rtl/dic_pkg.sv
// types and constants shared by the distinct id counter files
package dic_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ID_WIDTH   = 20;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int TRACK_W    = 20;
  localparam int EVENT_W    = 7;
  localparam int TOTAL_W    = 32;

  typedef struct packed {
    logic [TRACK_W-1:0] track_id;
    logic               point_valid;
    logic               event_last;
  } dic_point_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_tracks;
    logic [TOTAL_W-1:0] total_tracks;
    logic [TOTAL_W-1:0] event_count;
  } dic_result_t;

  typedef struct packed {
    logic             shift;
    logic [CNT_W-1:0] count;
  } dic_ctrl_t;

endpackage

// File: rtl/distinct_id_counter.sv
// top level of the distinct track identifier counter
//
// points come in on pt_valid / pt_ready / pt_data, one beat per point or
// per empty-event marker; the beat with event_last high closes the event.
// each new identifier is matched against all stored ones in the cell row
// in the same cycle and, if unseen and the row is not full, shifted in.
// one beat is taken per cycle while pt_ready is high: the match over the
// row is combinational and the count is updated as the beat is taken.
// the closing beat of an event yields one result beat on res_valid /
// res_ready / res_data in the cycle after: distinct count of that event,
// saturating running total of distinct tracks and saturating event count.
// the result sits in an output register; pt_ready stays high while it is
// empty or being taken, so a stalled receiver holds the input side only
// once a result is waiting and not taken.
// reset (rst, synchronous) empties the row, clears both totals and drops
// any waiting result; the block accepts beats in the first cycle after.
module distinct_id_counter
  import dic_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pt_valid,
  output logic        pt_ready,
  input  dic_point_t  pt_data,
  output logic        res_valid,
  input  logic        res_ready,
  output dic_result_t res_data
);

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_ins;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;
  logic [TOTAL_W-1:0] events;
  logic [TOTAL_W-1:0] events_next;
  logic [TOTAL_W:0]   sum;
  logic [ID_WIDTH-1:0] key;
  logic               accept;
  logic               found;
  logic               full;
  logic               insert;
  dic_ctrl_t          ctrl;

  assign pt_ready = !res_valid || res_ready;
  assign accept   = pt_valid && pt_ready;
  assign key      = ID_WIDTH'(pt_data.track_id);
  assign full     = count == CNT_W'(MAX_POINTS);
  assign insert   = accept && pt_data.point_valid && !found && !full;

  assign ctrl.shift = insert;
  assign ctrl.count = count;

  dic_chain u_chain (
    .clk   (clk),
    .key   (key),
    .ctrl  (ctrl),
    .found (found)
  );

  assign count_ins   = count + CNT_W'(insert);
  assign sum         = {1'b0, total} + (TOTAL_W + 1)'(count_ins);
  assign total_next  = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
  assign events_next = (&events) ? events : events + TOTAL_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      total     <= '0;
      events    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept && pt_data.event_last) begin
        count     <= '0;
        total     <= total_next;
        events    <= events_next;
        res_valid <= 1'b1;
      end else begin
        count <= count_ins;
        if (res_ready) begin
          res_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pt_data.event_last) begin
      res_data.event_tracks <= EVENT_W'(count_ins);
      res_data.total_tracks <= total_next;
      res_data.event_count  <= events_next;
    end
  end

endmodule

// File: rtl/dic_cell.sv
// one storage cell of the identifier chain
module dic_cell
  import dic_pkg::*;
(
  input  logic                clk,
  input  logic [ID_WIDTH-1:0] din,
  input  logic [ID_WIDTH-1:0] key,
  input  logic                shift,
  input  logic                occupied,
  output logic [ID_WIDTH-1:0] id,
  output logic                match
);

  always_ff @(posedge clk) begin
    if (shift) begin
      id <= din;
    end
  end

  assign match = occupied && (id == key);

endmodule

// File: rtl/dic_chain.sv
// row of identifier cells with shift-in insertion and parallel match
module dic_chain
  import dic_pkg::*;
(
  input  logic                clk,
  input  logic [ID_WIDTH-1:0] key,
  input  dic_ctrl_t           ctrl,
  output logic                found
);

  logic [ID_WIDTH-1:0]   link [MAX_POINTS+1];
  logic [MAX_POINTS-1:0] match;

  assign link[0] = key;

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic occupied;
    assign occupied = CNT_W'(i) < ctrl.count;

    dic_cell u_cell (
      .clk      (clk),
      .din      (link[i]),
      .key      (key),
      .shift    (ctrl.shift),
      .occupied (occupied),
      .id       (link[i+1]),
      .match    (match[i])
    );
  end

  assign found = |match;

endmodule

// File: rtl/dic_checker.sv
// port-level checks for the distinct id counter, bound to the top level
`include "distinct_id_counter_defines.svh"

module dic_checker
  import dic_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        pt_valid,
  input logic        pt_ready,
  input dic_point_t  pt_data,
  input logic        res_valid,
  input logic        res_ready,
  input dic_result_t res_data
);

  logic               pt_take;
  logic               res_take;
  logic               last_take;
  logic               res_grows;
  logic [TOTAL_W-1:0] prev_count;
  logic [TOTAL_W-1:0] prev_total;

  assign pt_take   = pt_valid && pt_ready;
  assign res_take  = res_valid && res_ready;
  assign last_take = pt_take && pt_data.event_last;
  assign res_grows = (res_data.event_count >= prev_count) &&
                     (res_data.total_tracks >= prev_total);

  always_ff @(posedge clk) begin
    prev_count <= res_data.event_count;
    prev_total <= res_data.total_tracks;
  end

  `DIC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data))
  `DIC_ASSERT_NOW(a_ready_when_empty, !res_valid, pt_ready)
  `DIC_ASSERT_NEXT(a_last_gives_result, last_take, res_valid)
  `DIC_ASSERT_NOW(a_count_nonzero, res_valid, res_data.event_count != '0)
  `DIC_ASSERT_NEXT(a_count_grows, res_take && last_take, res_grows)

endmodule

bind distinct_id_counter dic_checker u_dic_checker (.*);

// File: verif/distinct_id_counter_test.sv
// self-checking testbench for the distinct track identifier counter
`timescale 1ns / 1ps

module distinct_id_counter_test;
  import dic_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_GOAL   = 400;

  class distinct_tally;
    logic [ID_WIDTH-1:0] event_ids[$];
    logic [TOTAL_W-1:0]  track_sum;
    logic [TOTAL_W-1:0]  events_done;
    dic_result_t         summaries_due[$];
    int                  errors;

    function new();
      track_sum   = '0;
      events_done = '0;
      errors      = 0;
    endfunction

    function logic [TOTAL_W-1:0] sat_add(logic [TOTAL_W-1:0] a, logic [TOTAL_W-1:0] b);
      logic [TOTAL_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
    endfunction

    function void take_point(dic_point_t p);
      logic [ID_WIDTH-1:0] id;
      bit                  seen;
      dic_result_t         r;
      id   = ID_WIDTH'(p.track_id);
      seen = 0;
      if (p.point_valid) begin
        foreach (event_ids[i]) begin
          if (event_ids[i] == id) seen = 1;
        end
        if (!seen && event_ids.size() < MAX_POINTS) event_ids = {event_ids, id};
      end
      if (p.event_last) begin
        track_sum          = sat_add(track_sum, TOTAL_W'(event_ids.size()));
        events_done        = sat_add(events_done, TOTAL_W'(1));
        r.event_tracks     = EVENT_W'(event_ids.size());
        r.total_tracks     = track_sum;
        r.event_count      = events_done;
        summaries_due      = {summaries_due, r};
        event_ids.delete();
      end
    endfunction

    function void check_summary(dic_result_t got);
      dic_result_t want;
      if (summaries_due.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      want = summaries_due.pop_front();
      if (got.event_tracks !== want.event_tracks) begin
        $error("event_tracks expected %0d got %0d", want.event_tracks, got.event_tracks);
        errors++;
      end
      if (got.total_tracks !== want.total_tracks) begin
        $error("total_tracks expected %0d got %0d", want.total_tracks, got.total_tracks);
        errors++;
      end
      if (got.event_count !== want.event_count) begin
        $error("event_count expected %0d got %0d", want.event_count, got.event_count);
        errors++;
      end
    endfunction

    function int pending();
      return summaries_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        pt_valid = 1'b0;
  logic        pt_ready;
  dic_point_t  pt_data = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  dic_result_t res_data;

  distinct_tally tally = new();

  int send_idle_pct = 7;
  int recv_idle_pct = 52;
  int items_sent    = 0;
  int full_events   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  bit hold_req      = 0;
  bit hold_done     = 0;
  bit drain_done    = 0;

  distinct_id_counter dut (
    .clk(clk),
    .rst(rst),
    .pt_valid(pt_valid),
    .pt_ready(pt_ready),
    .pt_data(pt_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data(res_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) tally.check_summary(res_data);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        res_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 0;
        hold_left = HOLD_CYCLES;
        res_ready <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((pt_valid && pt_ready) || (res_valid && res_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic drive_beat(input dic_point_t p);
    pt_data  <= p;
    pt_valid <= 1'b1;
    @(posedge clk);
    while (!pt_ready) @(posedge clk);
    tally.take_point(p);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      pt_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_item(input logic [TRACK_W-1:0] id, input logic pv, input logic last);
    dic_point_t p;
    p.track_id    = id;
    p.point_valid = pv;
    p.event_last  = last;
    drive_beat(p);
    if (pv || last) items_sent++;
  endtask

  task automatic send_random_event();
    int                 kind;
    int                 n;
    int                 pool_n;
    logic [TRACK_W-1:0] pool[16];
    logic [TRACK_W-1:0] base;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      // empty event, sometimes behind ignored beats
      if ($urandom_range(0, 1)) send_item(TRACK_W'($urandom), 1'b0, 1'b0);
      send_item(TRACK_W'($urandom), 1'b0, 1'b1);
    end else if (kind < 11 && full_events < 3 && items_sent > 30) begin
      // overflow the store with more than the maximum of distinct ids
      full_events++;
      base = TRACK_W'($urandom);
      n    = MAX_POINTS + $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        send_item(base + TRACK_W'(i), 1'b1, 1'b0);
        if ($urandom_range(0, 9) == 0) send_item(base, 1'b1, 1'b0);
      end
      send_item(base + TRACK_W'($urandom_range(0, n + 5)), 1'($urandom_range(0, 1)), 1'b1);
    end else begin
      n      = $urandom_range(1, 12);
      pool_n = $urandom_range(1, (n < 16) ? n : 16);
      for (int i = 0; i < pool_n; i++) begin
        pool[i] = $urandom_range(0, 1) ? TRACK_W'($urandom) : TRACK_W'($urandom_range(0, 15));
      end
      for (int i = 0; i < n - 1; i++) begin
        if ($urandom_range(0, 9) == 0) send_item(TRACK_W'($urandom), 1'b0, 1'b0);
        send_item(pool[$urandom_range(0, pool_n - 1)], 1'b1, 1'b0);
      end
      send_item(pool[$urandom_range(0, pool_n - 1)], ($urandom_range(0, 4) != 0), 1'b1);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty events, extreme ids, repeats, ignored beats
    send_item(20'h00000, 1'b0, 1'b1);
    send_item(20'hFFFFF, 1'b0, 1'b0);
    send_item(20'h00000, 1'b1, 1'b0);
    send_item(20'hFFFFF, 1'b1, 1'b0);
    send_item(20'h00000, 1'b1, 1'b0);
    send_item(20'hFFFFF, 1'b1, 1'b1);
    send_item(20'hAAAAA, 1'b1, 1'b1);
    send_item(20'h55555, 1'b1, 1'b0);
    send_item(20'h12345, 1'b1, 1'b0);
    send_item(20'hFFFFF, 1'b0, 1'b1);
    send_item(20'h00000, 1'b0, 1'b1);
    send_item(20'hFFFFF, 1'b0, 1'b1);
    send_item(20'h80000, 1'b1, 1'b0);
    send_item(20'h00001, 1'b1, 1'b0);
    send_item(20'h7FFFF, 1'b1, 1'b0);
    send_item(20'h80000, 1'b1, 1'b0);
    send_item(20'h00001, 1'b1, 1'b1);

    while (items_sent < ITEM_GOAL) begin
      if (items_sent > (2 * ITEM_GOAL) / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items_sent > ITEM_GOAL / 3) begin
        send_idle_pct = 52;
        recv_idle_pct = 7;
      end
      if (!hold_done && items_sent > 100) begin
        hold_done = 1;
        hold_req  = 1;
      end
      if (!drain_done && items_sent > 250) begin
        // drain everything before going on
        drain_done = 1;
        pt_valid <= 1'b0;
        while (tally.pending() > 0) @(posedge clk);
      end
      send_random_event();
    end
    pt_valid <= 1'b0;

    while (tally.pending() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tally.errors == 0 && tally.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
